// ===== src/software_timer_table_unit_macros.svh =====
// Assertion macros shared by the timer table.
`ifndef SOFTWARE_TIMER_TABLE_UNIT_MACROS_SVH
`define SOFTWARE_TIMER_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define STTU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timer table check failed");

// Next-cycle implication, checked outside reset.
`define STTU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timer table check failed");

`endif

// ===== src/sttu_pkg.sv =====
package sttu_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam logic [15:0] TICK_STEP_RESET = 16'd10;

  localparam logic [2:0] REQ_START_CYCLIC = 3'd0;
  localparam logic [2:0] REQ_SET_ALARM    = 3'd1;
  localparam logic [2:0] REQ_CANCEL       = 3'd2;
  localparam logic [2:0] REQ_STOP_OWNER   = 3'd3;
  localparam logic [2:0] REQ_QUERY        = 3'd4;
  localparam logic [2:0] REQ_TICK         = 3'd5;

  localparam logic [1:0] KIND_REPLY  = 2'd0;
  localparam logic [1:0] KIND_CYCLIC = 2'd1;
  localparam logic [1:0] KIND_ALARM  = 2'd2;

  localparam logic [1:0] SEL_HOLD       = 2'd0;
  localparam logic [1:0] SEL_TAKE_RIGHT = 2'd1;
  localparam logic [1:0] SEL_TAKE_LEFT  = 2'd2;
  localparam logic [1:0] SEL_LOAD       = 2'd3;

  typedef struct packed {
    logic        valid;
    logic        alive;
    logic        alarm;
    logic [7:0]  owner;
    logic [15:0] timer;
    logic [31:0] interval;
    logic [31:0] start;
  } entry_t;

endpackage

// ===== src/sttu_cell.sv =====
module sttu_cell
  import sttu_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic [1:0] sel,
  input  entry_t left_in,
  input  entry_t right_in,
  input  entry_t load_in,
  output entry_t q
);

  entry_t q_next;

  always_comb begin
    case (sel)
      SEL_HOLD:       q_next = q;
      SEL_TAKE_RIGHT: q_next = right_in;
      SEL_TAKE_LEFT:  q_next = left_in;
      SEL_LOAD:       q_next = load_in;
      default:        q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else begin
      q <= q_next;
    end
  end

endmodule

// ===== src/software_timer_table_unit.sv =====
// Timer table with up to DEPTH cyclic or one-shot timers, keyed by owner and timer number.
// Commands enter on the s_ channel: s_tuser carries the request type, s_tdata the owner,
// timer number and interval. Results leave on the m_ channel, one item per reply or expiry;
// m_tlast marks the final item caused by a command. The tick step register is written
// through cfg_valid/cfg_data; the user must write it only while the block is idle, as
// the block itself does not enforce it. Entries sit in a row of cells that all shift
// towards cell 0 together; cell 0 is inspected and the item returns at the tail, so one
// pass visits every entry. Start, cancel, stop-owner and query make one such pass. A tick
// makes one pass to fire due entries and then an odd-even exchange pass that squeezes
// dead entries out while keeping order. A tick on an empty table clears the clock and
// gives no item. A start on a full table and an unknown request skip the pass. One
// command is handled at a time.
// Reset empties the table, clears the clock and sets the tick step to ten.
// When the receiver stalls, the output register holds its item; a scan pauses only if a new
// due entry meets a pending one, and flush and reply wait. Nothing is lost or repeated.
module software_timer_table_unit
  import sttu_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // owner_id[7:0], timer_id[23:8], interval[55:24]
  input  logic [2:0]  s_tuser,   // req_type[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // out_owner[7:0], out_timer[23:8], ok[24], zero fill
  output logic [1:0]  m_tuser,   // result_kind[1:0]
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  `include "software_timer_table_unit_macros.svh"

  localparam int IW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_SORT  = 3'd2;
  localparam logic [2:0] ST_FLUSH = 3'd3;
  localparam logic [2:0] ST_REPLY = 3'd4;

  logic [2:0]     state;
  logic [IW-1:0]  step;
  logic [CNW-1:0] count;
  logic [CNW-1:0] surv;
  logic [31:0]    running_time;
  logic [15:0]    tick_step;
  logic [2:0]     req;
  logic [7:0]     req_owner;
  logic [15:0]    req_timer;
  logic [31:0]    req_interval;
  logic           found;
  logic           ok_r;

  logic           pend_v;
  logic [1:0]     pend_kind;
  logic [7:0]     pend_owner;
  logic [15:0]    pend_timer;

  logic           out_v;
  logic [1:0]     out_kind;
  logic [7:0]     out_owner;
  logic [15:0]    out_timer;
  logic           out_ok;
  logic           out_last;

  entry_t         cells_q [DEPTH];
  logic [1:0]     sel [DEPTH];
  entry_t         head;
  entry_t         wb;
  entry_t         load_e;
  logic           key_hit;
  logic           owner_hit;
  logic [31:0]    diff;
  logic [31:0]    elapsed;
  logic           due;
  logic           expire;
  logic           out_free;
  logic           scan_go;
  logic           last_step;
  logic           req_start;
  logic           out_load;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_v;
  assign m_tdata   = {7'd0, out_ok, out_timer, out_owner};
  assign m_tuser   = out_kind;
  assign m_tlast   = out_last;

  assign out_free  = !out_v || m_tready;
  assign last_step = (step == IW'(DEPTH - 1));
  assign req_start = (req == REQ_START_CYCLIC) || (req == REQ_SET_ALARM);

  assign head      = cells_q[0];
  assign key_hit   = (head.owner == req_owner) && (head.timer == req_timer);
  assign owner_hit = (head.owner == req_owner);
  assign diff      = running_time - head.start;
  assign elapsed   = (head.start <= running_time) ? diff : diff - 32'd1;
  assign due       = (elapsed >= head.interval);

  always_comb begin
    wb     = head;
    expire = 1'b0;
    case (req)
      REQ_START_CYCLIC, REQ_SET_ALARM: begin
        if (head.valid && head.alive && key_hit && !found) begin
          wb.alive = 1'b0;
        end
      end
      REQ_CANCEL: begin
        if (head.valid && key_hit) begin
          wb.alive = 1'b0;
        end
      end
      REQ_STOP_OWNER: begin
        if (head.valid && owner_hit) begin
          wb.alive = 1'b0;
        end
      end
      REQ_TICK: begin
        if (head.valid && head.alive && due) begin
          expire = 1'b1;
          if (head.alarm) begin
            wb.alive = 1'b0;
          end else begin
            wb.start = head.start + head.interval;
          end
        end
        wb.valid = head.valid && wb.alive;
      end
      default: begin
        wb = head;
      end
    endcase
  end

  assign scan_go = !expire || !pend_v || out_free;

  assign out_load = (state == ST_SCAN && scan_go && expire && pend_v) ||
                    (state == ST_FLUSH && pend_v && out_free) ||
                    (state == ST_REPLY && out_free);

  always_comb begin
    load_e.valid    = 1'b1;
    load_e.alive    = 1'b1;
    load_e.alarm    = (req == REQ_SET_ALARM);
    load_e.owner    = req_owner;
    load_e.timer    = req_timer;
    load_e.interval = req_interval;
    load_e.start    = running_time;
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      sel[i] = SEL_HOLD;
      if (state == ST_SCAN && scan_go) begin
        sel[i] = SEL_TAKE_RIGHT;
      end else if (state == ST_SORT) begin
        if (i + 1 < DEPTH && (i % 2) == int'(step[0]) &&
            !cells_q[i].valid && cells_q[(i + 1) % DEPTH].valid) begin
          sel[i] = SEL_TAKE_RIGHT;
        end
        if (i >= 1 && ((i - 1) % 2) == int'(step[0]) &&
            !cells_q[(i + DEPTH - 1) % DEPTH].valid && cells_q[i].valid) begin
          sel[i] = SEL_TAKE_LEFT;
        end
      end else if (state == ST_REPLY && out_free && ok_r &&
                   (req == REQ_START_CYCLIC || req == REQ_SET_ALARM) &&
                   count == CNW'(i)) begin
        sel[i] = SEL_LOAD;
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    sttu_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .sel      (sel[g]),
      .left_in  (cells_q[(g + DEPTH - 1) % DEPTH]),
      .right_in ((g == DEPTH - 1) ? wb : cells_q[(g + 1) % DEPTH]),
      .load_in  (load_e),
      .q        (cells_q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_step <= TICK_STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tick_step <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (out_load) begin
      out_v <= 1'b1;
    end else if (m_tready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == ST_REPLY) begin
        out_kind  <= KIND_REPLY;
        out_owner <= req_owner;
        out_timer <= req_timer;
        out_ok    <= ok_r;
      end else begin
        out_kind  <= pend_kind;
        out_owner <= pend_owner;
        out_timer <= pend_timer;
        out_ok    <= 1'b0;
      end
      out_last <= (state != ST_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
    end else if (state == ST_SCAN && scan_go && expire) begin
      pend_v     <= 1'b1;
      pend_kind  <= head.alarm ? KIND_ALARM : KIND_CYCLIC;
      pend_owner <= head.owner;
      pend_timer <= head.timer;
    end else if (state == ST_FLUSH && out_free) begin
      pend_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      running_time <= '0;
      step         <= '0;
      surv         <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            req          <= s_tuser;
            req_owner    <= s_tdata[7:0];
            req_timer    <= s_tdata[23:8];
            req_interval <= s_tdata[55:24];
            found        <= 1'b0;
            surv         <= '0;
            step         <= '0;
            case (s_tuser)
              REQ_START_CYCLIC, REQ_SET_ALARM: begin
                if (count == CNW'(DEPTH)) begin
                  ok_r  <= 1'b0;
                  state <= ST_REPLY;
                end else begin
                  ok_r  <= 1'b1;
                  state <= ST_SCAN;
                end
              end
              REQ_CANCEL, REQ_STOP_OWNER, REQ_QUERY: begin
                ok_r  <= 1'b0;
                state <= ST_SCAN;
              end
              REQ_TICK: begin
                ok_r <= 1'b0;
                if (count == '0) begin
                  running_time <= '0;
                  state        <= ST_IDLE;
                end else begin
                  running_time <= running_time + {16'd0, tick_step};
                  state        <= ST_SCAN;
                end
              end
              default: begin
                ok_r  <= 1'b0;
                state <= ST_REPLY;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (scan_go) begin
            if (head.valid && key_hit && !found) begin
              if (req == REQ_QUERY) begin
                found <= 1'b1;
                ok_r  <= head.alive;
              end else if (req_start && head.alive) begin
                found <= 1'b1;
              end
            end
            if (wb.valid) begin
              surv <= surv + CNW'(1);
            end
            if (last_step) begin
              step <= '0;
              if (req == REQ_TICK) begin
                count <= wb.valid ? surv + CNW'(1) : surv;
                state <= ST_SORT;
              end else begin
                state <= ST_REPLY;
              end
            end else begin
              step <= step + IW'(1);
            end
          end
        end
        ST_SORT: begin
          if (last_step) begin
            step  <= '0;
            state <= ST_FLUSH;
          end else begin
            step <= step + IW'(1);
          end
        end
        ST_FLUSH: begin
          if (!pend_v || out_free) begin
            state <= ST_IDLE;
          end
        end
        ST_REPLY: begin
          if (out_free) begin
            if (ok_r && req_start) begin
              count <= count + CNW'(1);
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `STTU_ASSERT_NOW(a_count_bound, 1'b1, count <= CNW'(DEPTH))
  `STTU_ASSERT_NEXT(a_empty_tick_clears,
      s_tvalid && s_tready && s_tuser == REQ_TICK && count == '0, running_time == '0)
  `STTU_ASSERT_NOW(a_pend_only_tick, pend_v, req == REQ_TICK)

endmodule
